[hw/rtl/sgi_pkg.sv]
`default_nettype none

package sgi_pkg;

  localparam int CoordW = 32;
  localparam int DeltaW = CoordW + 1;
  localparam int ProdW  = 2 * DeltaW;       // cross product of two deltas
  localparam int NumW   = ProdW;            // signed numerators
  localparam int DenW   = ProdW - 1;        // magnitude of the denominator
  localparam int PointW = 100;              // x1*den + dax*num, signed
  localparam int MagW   = PointW - 1;
  localparam int RemW   = 97;               // |n| below (2^31+1)*den when not saturated
  localparam int QuoW   = 32;
  localparam int DivStages = QuoW;

  localparam logic [1:0] ST_INSIDE   = 2'd0;
  localparam logic [1:0] ST_OUTSIDE  = 2'd1;
  localparam logic [1:0] ST_PARALLEL = 2'd2;
  localparam logic [1:0] ST_DEGEN_A  = 2'd3;

  // crossing in parametric form, sign of den already folded into num
  typedef struct packed {
    logic [1:0]        status;
    logic              use_pt;    // degenerate B: point is B start
    logic [DenW-1:0]   den;
    logic [NumW-1:0]   num;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
    logic [CoordW-1:0] x3;
    logic [CoordW-1:0] y3;
    logic [DeltaW-1:0] dax;
    logic [DeltaW-1:0] day;
  } geo_t;

  typedef struct packed {
    logic            sat;
    logic            neg;
    logic [RemW-1:0] mag;
    logic [DenW-1:0] den;
  } div_in_t;

endpackage

`default_nettype wire

[hw/rtl/segment_intersection_2d.sv]
// Exact crossing of two 2D segments, coordinates signed Q16.16.
// Input channel s_*: one beat carries both segments on s_tdata, lowest bits
// first: A start x, A start y, A end x, A end y, B start x, B start y,
// B end x, B end y (32 bits each).
// Output channel m_*: one beat per input beat, in order. m_tuser holds the
// status (inside both boxes, outside, parallel/point off line, A degenerate);
// m_tdata holds cross x then cross y, truncated toward zero and saturated,
// zero for parallel and degenerate cases.
// Throughput: one beat per cycle while the pipe is not stalled. The path is 4
// geometry stages (deltas, cross products, numerators, classify), 5 point
// stages (split 33x34 products, recombine, sum, magnitude, saturation), then
// 32 restoring divider stages per axis, then the output register.
// Stall: the whole pipe moves on a single enable. A skid register behind the
// output register catches the beat in flight when m_tready drops; s_tready
// falls only once the skid is full, so nothing is lost or repeated.
// Reset clears all valid bits, m_tvalid and the skid-full flag; no clearing pass.
`default_nettype none

module segment_intersection_2d (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [255:0] s_tdata,   // seg_a_start_x, seg_a_start_y, seg_a_end_x,
                                       // seg_a_end_y, seg_b_start_x, seg_b_start_y,
                                       // seg_b_end_x, seg_b_end_y
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [63:0]       m_tdata,   // cross_x, cross_y
  output logic [1:0]        m_tuser    // status
);

  logic en;
  logic skid_full;

  assign en       = !skid_full;
  assign s_tready = en;

  // geometry front end
  logic          f_valid;
  sgi_pkg::geo_t f_geo;

  sgi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .a_sx      ($signed(s_tdata[31:0])),
    .a_sy      ($signed(s_tdata[63:32])),
    .a_ex      ($signed(s_tdata[95:64])),
    .a_ey      ($signed(s_tdata[127:96])),
    .b_sx      ($signed(s_tdata[159:128])),
    .b_sy      ($signed(s_tdata[191:160])),
    .b_ex      ($signed(s_tdata[223:192])),
    .b_ey      ($signed(s_tdata[255:224])),
    .out_valid (f_valid),
    .geo       (f_geo)
  );

  // crossing numerators and saturation
  logic              p_valid;
  logic [1:0]        p_status;
  sgi_pkg::div_in_t  p_dx, p_dy;

  sgi_point u_point (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .geo       (f_geo),
    .out_valid (p_valid),
    .status    (p_status),
    .div_x     (p_dx),
    .div_y     (p_dy)
  );

  // one divider per axis
  logic              dx_valid, dy_valid;
  logic signed [31:0] qx, qy;

  sgi_div u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .din       (p_dx),
    .out_valid (dx_valid),
    .quo       (qx)
  );

  sgi_div u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .din       (p_dy),
    .out_valid (dy_valid),
    .quo       (qy)
  );

  // status rides alongside the dividers
  logic [1:0] st_dly [0:sgi_pkg::DivStages-1];

  always_ff @(posedge clk) begin
    if (en) begin
      st_dly[0] <= p_status;
      for (int k = 1; k < sgi_pkg::DivStages; k++) st_dly[k] <= st_dly[k-1];
    end
  end

  logic        r_valid;
  logic [1:0]  r_status;
  logic [63:0] r_data;
  logic        emit;

  always_comb begin
    r_valid  = dx_valid && dy_valid;
    r_status = st_dly[sgi_pkg::DivStages-1];
    // parallel and degenerate cases report a zero point
    r_data   = (r_status inside {sgi_pkg::ST_PARALLEL, sgi_pkg::ST_DEGEN_A}) ?
               64'd0 : {qy, qx};
    emit     = en && r_valid;
  end

  // output register plus skid
  logic [63:0] skid_data;
  logic [1:0]  skid_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      skid_full <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_full) begin
        m_tvalid  <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        m_tvalid  <= emit;
      end
    end else if (emit) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_full) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end else begin
        m_tdata <= r_data;
        m_tuser <= r_status;
      end
    end else if (emit) begin
      skid_data <= r_data;
      skid_user <= r_status;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sgi_front.sv]
`default_nettype none

module sgi_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic signed [31:0]    a_sx,
  input  wire logic signed [31:0]    a_sy,
  input  wire logic signed [31:0]    a_ex,
  input  wire logic signed [31:0]    a_ey,
  input  wire logic signed [31:0]    b_sx,
  input  wire logic signed [31:0]    b_sy,
  input  wire logic signed [31:0]    b_ex,
  input  wire logic signed [31:0]    b_ey,
  output logic                       out_valid,
  output sgi_pkg::geo_t              geo
);

  // stage 1: deltas and A's box
  logic v1;
  logic signed [32:0] dax1, day1, dbx1, dby1, ex1, ey1;
  logic signed [31:0] x1_1, y1_1, x3_1, y3_1, axlo1, axhi1, aylo1, ayhi1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dax1  <= 33'(a_ex) - 33'(a_sx);
      day1  <= 33'(a_ey) - 33'(a_sy);
      dbx1  <= 33'(b_ex) - 33'(b_sx);
      dby1  <= 33'(b_ey) - 33'(b_sy);
      ex1   <= 33'(b_sx) - 33'(a_sx);
      ey1   <= 33'(b_sy) - 33'(a_sy);
      x1_1  <= a_sx;
      y1_1  <= a_sy;
      x3_1  <= b_sx;
      y3_1  <= b_sy;
      axlo1 <= (a_sx < a_ex) ? a_sx : a_ex;
      axhi1 <= (a_sx < a_ex) ? a_ex : a_sx;
      aylo1 <= (a_sy < a_ey) ? a_sy : a_ey;
      ayhi1 <= (a_sy < a_ey) ? a_ey : a_sy;
    end
  end

  // stage 2: cross products
  logic v2, dega2, degb2, boxpt2;
  logic signed [65:0] p_adb2, p_bda2, p_edb2, p_fdb2, p_eda2, p_fda2;
  logic signed [31:0] x1_2, y1_2, x3_2, y3_2;
  logic signed [32:0] dax2, day2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_adb2 <= dax1 * dby1;
      p_bda2 <= day1 * dbx1;
      p_edb2 <= ex1 * dby1;
      p_fdb2 <= ey1 * dbx1;
      p_eda2 <= ex1 * day1;
      p_fda2 <= ey1 * dax1;
      dega2  <= (dax1 == 33'sd0) && (day1 == 33'sd0);
      degb2  <= (dbx1 == 33'sd0) && (dby1 == 33'sd0);
      boxpt2 <= (x3_1 >= axlo1) && (x3_1 <= axhi1) && (y3_1 >= aylo1) && (y3_1 <= ayhi1);
      x1_2   <= x1_1;
      y1_2   <= y1_1;
      x3_2   <= x3_1;
      y3_2   <= y3_1;
      dax2   <= dax1;
      day2   <= day1;
    end
  end

  // stage 3: den = A x B, t and u numerators
  logic v3, dega3, degb3, boxpt3;
  logic signed [65:0] den3, num3, numu3;
  logic signed [31:0] x1_3, y1_3, x3_3, y3_3;
  logic signed [32:0] dax3, day3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den3   <= p_adb2 - p_bda2;
      num3   <= p_edb2 - p_fdb2;
      numu3  <= p_eda2 - p_fda2;
      dega3  <= dega2;
      degb3  <= degb2;
      boxpt3 <= boxpt2;
      x1_3   <= x1_2;
      y1_3   <= y1_2;
      x3_3   <= x3_2;
      y3_3   <= y3_2;
      dax3   <= dax2;
      day3   <= day2;
    end
  end

  // stage 4: normalize sign, classify. Inside both boxes <=> 0 <= t,u <= 1.
  logic signed [65:0] den_p, num_p, numu_p;
  logic               t_in, u_in;
  logic [1:0]         status_c;
  logic               v4;

  always_comb begin
    den_p  = den3[65] ? -den3  : den3;
    num_p  = den3[65] ? -num3  : num3;
    numu_p = den3[65] ? -numu3 : numu3;
    t_in   = !num_p[65]  && (num_p <= den_p);
    u_in   = !numu_p[65] && (numu_p <= den_p);
    if (dega3) begin
      status_c = sgi_pkg::ST_DEGEN_A;
    end else if (degb3) begin
      // B is a point: it must lie on A's line
      if (numu3 != 66'sd0) status_c = sgi_pkg::ST_PARALLEL;
      else status_c = boxpt3 ? sgi_pkg::ST_INSIDE : sgi_pkg::ST_OUTSIDE;
    end else if (den3 == 66'sd0) begin
      status_c = sgi_pkg::ST_PARALLEL;
    end else begin
      status_c = (t_in && u_in) ? sgi_pkg::ST_INSIDE : sgi_pkg::ST_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo.status <= status_c;
      geo.use_pt <= degb3;
      geo.den    <= degb3 ? sgi_pkg::DenW'(1) : den_p[sgi_pkg::DenW-1:0];
      geo.num    <= num_p;
      geo.x1     <= x1_3;
      geo.y1     <= y1_3;
      geo.x3     <= x3_3;
      geo.y3     <= y3_3;
      geo.dax    <= dax3;
      geo.day    <= day3;
    end
  end

  assign out_valid = v4;

endmodule

`default_nettype wire

[hw/rtl/sgi_point.sv]
`default_nettype none

module sgi_point (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire sgi_pkg::geo_t  geo,
  output logic                out_valid,
  output logic [1:0]          status,
  output sgi_pkg::div_in_t    div_x,
  output sgi_pkg::div_in_t    div_y
);

  // stage 1: partial products, den and num split at bit 33
  logic v1, use_pt1;
  logic [1:0] st1;
  logic [64:0] den1;
  logic signed [31:0] x3_1, y3_1;
  logic signed [65:0] pxl1, pyl1, pah1, pbh1;
  logic signed [64:0] pxh1, pyh1;
  logic signed [66:0] pal1, pbl1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxl1    <= $signed(geo.x1) * $signed({1'b0, geo.den[32:0]});
      pxh1    <= $signed(geo.x1) * $signed({1'b0, geo.den[64:33]});
      pyl1    <= $signed(geo.y1) * $signed({1'b0, geo.den[32:0]});
      pyh1    <= $signed(geo.y1) * $signed({1'b0, geo.den[64:33]});
      pal1    <= $signed(geo.dax) * $signed({1'b0, geo.num[32:0]});
      pah1    <= $signed(geo.dax) * $signed(geo.num[65:33]);
      pbl1    <= $signed(geo.day) * $signed({1'b0, geo.num[32:0]});
      pbh1    <= $signed(geo.day) * $signed(geo.num[65:33]);
      st1     <= geo.status;
      use_pt1 <= geo.use_pt;
      den1    <= geo.den;
      x3_1    <= $signed(geo.x3);
      y3_1    <= $signed(geo.y3);
    end
  end

  // stage 2: recombine halves
  logic v2, use_pt2;
  logic [1:0] st2;
  logic [64:0] den2;
  logic signed [31:0] x3_2, y3_2;
  logic signed [99:0] nxa2, nxb2, nya2, nyb2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nxa2    <= (100'(pxh1) <<< 33) + 100'(pxl1);
      nxb2    <= (100'(pah1) <<< 33) + 100'(pal1);
      nya2    <= (100'(pyh1) <<< 33) + 100'(pyl1);
      nyb2    <= (100'(pbh1) <<< 33) + 100'(pbl1);
      st2     <= st1;
      use_pt2 <= use_pt1;
      den2    <= den1;
      x3_2    <= x3_1;
      y3_2    <= y3_1;
    end
  end

  // stage 3: numerators of the point, nx/den and ny/den
  logic v3;
  logic [1:0] st3;
  logic [64:0] den3;
  logic signed [99:0] nx3, ny3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx3  <= use_pt2 ? 100'(x3_2) : nxa2 + nxb2;
      ny3  <= use_pt2 ? 100'(y3_2) : nya2 + nyb2;
      st3  <= st2;
      den3 <= den2;
    end
  end

  // stage 4: magnitudes and saturation thresholds
  logic v4, negx4, negy4;
  logic [1:0] st4;
  logic [64:0] den4;
  logic [98:0] magx4, magy4;
  logic [96:0] thr_pos4, thr_neg4;
  logic signed [99:0] absx, absy;

  always_comb begin
    absx = nx3[99] ? -nx3 : nx3;
    absy = ny3[99] ? -ny3 : ny3;
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negx4    <= nx3[99];
      negy4    <= ny3[99];
      magx4    <= absx[98:0];
      magy4    <= absy[98:0];
      thr_pos4 <= {1'b0, den3, 31'b0};
      thr_neg4 <= {1'b0, den3, 31'b0} + 97'(den3);
      st4      <= st3;
      den4     <= den3;
    end
  end

  // stage 5: saturation, quotient fits 32 bits otherwise
  logic satx, saty;
  logic v5;

  always_comb begin
    satx = negx4 ? (magx4 >= 99'(thr_neg4)) : (magx4 >= 99'(thr_pos4));
    saty = negy4 ? (magy4 >= 99'(thr_neg4)) : (magy4 >= 99'(thr_pos4));
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_x.sat <= satx;
      div_x.neg <= negx4;
      div_x.mag <= satx ? '0 : magx4[96:0];
      div_x.den <= den4;
      div_y.sat <= saty;
      div_y.neg <= negy4;
      div_y.mag <= saty ? '0 : magy4[96:0];
      div_y.den <= den4;
      status    <= st4;
    end
  end

  assign out_valid = v5;

endmodule

`default_nettype wire

[hw/rtl/sgi_div.sv]
`default_nettype none

module sgi_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire sgi_pkg::div_in_t  din,
  output logic                   out_valid,
  output logic signed [31:0]     quo
);

  localparam int N = sgi_pkg::DivStages;

  // restoring division, one quotient bit per stage, MSB first
  logic                     v   [1:N];
  logic [sgi_pkg::RemW-1:0] rem [1:N];
  logic [31:0]              q   [1:N];
  logic [sgi_pkg::DenW-1:0] den [1:N];
  logic                     neg [1:N];
  logic                     sat [1:N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int B = N - 1 - s;
    logic                     cv, cneg, csat;
    logic [sgi_pkg::RemW-1:0] crem;
    logic [31:0]              cq;
    logic [sgi_pkg::DenW-1:0] cden;
    logic [sgi_pkg::RemW:0]   trial;

    if (s == 0) begin : g_first
      assign cv   = in_valid;
      assign crem = din.mag;
      assign cq   = '0;
      assign cden = din.den;
      assign cneg = din.neg;
      assign csat = din.sat;
    end else begin : g_next
      assign cv   = v[s];
      assign crem = rem[s];
      assign cq   = q[s];
      assign cden = den[s];
      assign cneg = neg[s];
      assign csat = sat[s];
    end

    assign trial = {1'b0, crem} - ((sgi_pkg::RemW + 1)'(cden) << B);

    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else if (en) v[s+1] <= cv;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]    <= trial[sgi_pkg::RemW] ? crem : trial[sgi_pkg::RemW-1:0];
        q[s+1]      <= cq | (32'(!trial[sgi_pkg::RemW]) << B);
        den[s+1]    <= cden;
        neg[s+1]    <= cneg;
        sat[s+1]    <= csat;
      end
    end
  end

  always_comb begin
    if (sat[N]) quo = neg[N] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else quo = neg[N] ? -$signed(q[N]) : $signed(q[N]);
  end

  assign out_valid = v[N];

endmodule

`default_nettype wire
